@@ sv/hcb_pkg.sv @@
package hcb_pkg;

  localparam int NUM_SYMBOLS_DEF   = 256;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int MAX_CODE_BITS_DEF = 64;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_DECODE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_BUILT = 2'd1,
    STS_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  symbol;
    logic [31:0] frequency;
    logic        code_bit;
  } hcb_req_t;

  typedef struct packed {
    status_t     status;
    logic        symbol_valid;
    logic [7:0]  decoded_symbol;
    logic [63:0] code_value;
    logic [6:0]  code_length;
  } hcb_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_LIVE,
    ST_RD_NODE,
    ST_CMP,
    ST_CMP2,
    ST_MERGE,
    ST_RD_LAST,
    ST_MOVE,
    ST_WROOT,
    ST_WRD,
    ST_WL,
    ST_WR,
    ST_LOOKUP,
    ST_DECODE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

@@ sv/hcb_cmp.sv @@
module hcb_cmp #(
  parameter int KEY_BITS = 48
) (
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  output logic                less
);
  // key is weight above lowest symbol, so one compare gives the tie break
  assign less = (a < b);
endmodule

@@ sv/hcb_engine.sv @@
module hcb_engine #(
  parameter int NUM_SYMBOLS   = hcb_pkg::NUM_SYMBOLS_DEF,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hcb_pkg::eng_ctl_t ctl,
  input  hcb_pkg::hcb_req_t req,
  output hcb_pkg::eng_sts_t sts,
  output hcb_pkg::hcb_rsp_t result
);
  import hcb_pkg::*;

  localparam int SB   = $clog2(NUM_SYMBOLS);
  localparam int NB   = $clog2(2 * NUM_SYMBOLS - 1);
  localparam int WB   = COUNT_BITS + 8;
  localparam int KB   = WB + SB;
  localparam int LB   = $clog2(MAX_CODE_BITS + 2);
  localparam int ROOT = 2 * NUM_SYMBOLS - 2;

  state_t state, state_next;

  logic            tree_ready;
  logic [NB-1:0]   pos;
  logic [SB-1:0]   i;
  logic [SB:0]     cnt;
  logic [SB-1:0]   m;
  logic            too_long;
  logic            have_first, have_second;
  logic [KB-1:0]   first_key, second_key;
  logic [NB-1:0]   first_node, second_node;
  logic [SB-1:0]   first_idx, second_idx;
  logic [NB-1:0]   cur_node;
  logic            cur_leaf;
  hcb_req_t        req_q;

  // storage
  logic [COUNT_BITS-1:0]        counts_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]       counts_vld;
  logic [KB-1:0]                node_mem [NUM_SYMBOLS-1];
  logic [2*NB-1:0]              lr_mem [NUM_SYMBOLS-1];
  logic [NB-1:0]                live_mem [NUM_SYMBOLS];
  logic [MAX_CODE_BITS+LB-1:0]  walk_mem [2*NUM_SYMBOLS-1];

  logic [COUNT_BITS-1:0]       counts_q;
  logic [KB-1:0]               node_q;
  logic [2*NB-1:0]             lr_q;
  logic [NB-1:0]               live_q;
  logic [MAX_CODE_BITS+LB-1:0] walk_q;

  logic                  counts_we, counts_re;
  logic [SB-1:0]         counts_waddr, counts_raddr;
  logic                  node_we, node_re;
  logic [SB-1:0]         node_raddr;
  logic                  lr_we, lr_re;
  logic [SB-1:0]         lr_raddr;
  logic                  live_we, live_re;
  logic [SB-1:0]         live_waddr, live_raddr;
  logic [NB-1:0]         live_wdata;
  logic                  walk_we, walk_re;
  logic [NB-1:0]         walk_waddr, walk_raddr;
  logic [MAX_CODE_BITS+LB-1:0] walk_wdata;

  // datapath
  logic                     sym_ok;
  logic                     not_built;
  logic [NB-1:0]            live_off, pos_off, parent;
  logic [KB-1:0]            cur_key, cmp_b;
  logic                     less;
  logic                     last;
  logic [WB-1:0]            sum;
  logic [SB-1:0]            low_min;
  logic [MAX_CODE_BITS-1:0] pcode, ncode;
  logic [LB-1:0]            plen, nlen;
  logic [NB-1:0]            child, dec_next;
  logic                     child_long;

  assign sym_ok   = ({1'b0, req.symbol} < 9'(NUM_SYMBOLS));
  assign not_built = !tree_ready &&
                     (req.req_type == REQ_LOOKUP || req.req_type == REQ_DECODE);
  assign live_off = live_q - NB'(NUM_SYMBOLS);
  assign pos_off  = pos - NB'(NUM_SYMBOLS);
  assign parent   = NB'(NUM_SYMBOLS) + NB'(m);
  assign cur_key  = cur_leaf ? {WB'(counts_q), cur_node[SB-1:0]} : node_q;
  assign cmp_b    = (state == ST_CMP) ? first_key : second_key;
  assign last     = ({1'b0, i} == cnt - (SB+1)'(1));
  assign sum      = first_key[KB-1:SB] + second_key[KB-1:SB];
  assign low_min  = (first_key[SB-1:0] < second_key[SB-1:0]) ?
                    first_key[SB-1:0] : second_key[SB-1:0];

  assign pcode = walk_q[MAX_CODE_BITS+LB-1:LB];
  assign plen  = walk_q[LB-1:0];
  assign nlen  = (plen <= LB'(MAX_CODE_BITS)) ? plen + LB'(1) : plen;
  assign ncode = {pcode[MAX_CODE_BITS-2:0], (state == ST_WR)};
  assign child = (state == ST_WR) ? lr_q[NB-1:0] : lr_q[2*NB-1:NB];
  assign child_long = (child < NB'(NUM_SYMBOLS)) && (nlen > LB'(MAX_CODE_BITS));
  assign dec_next = req_q.code_bit ? lr_q[NB-1:0] : lr_q[2*NB-1:NB];

  hcb_cmp #(.KEY_BITS(KB)) u_cmp (
    .a    (cur_key),
    .b    (cmp_b),
    .less (less)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          unique case (req.req_type)
            REQ_LOAD:   state_next = ST_RESP;
            REQ_BUILD:  state_next = ST_INIT;
            REQ_LOOKUP: state_next = (tree_ready && sym_ok) ? ST_LOOKUP : ST_RESP;
            REQ_DECODE: state_next = tree_ready ? ST_DECODE : ST_RESP;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_INIT:    if (i == SB'(NUM_SYMBOLS - 1)) state_next = ST_RD_LIVE;
      ST_RD_LIVE: state_next = ST_RD_NODE;
      ST_RD_NODE: state_next = ST_CMP;
      ST_CMP: begin
        if (!have_first || less) state_next = last ? ST_MERGE : ST_RD_LIVE;
        else state_next = ST_CMP2;
      end
      ST_CMP2:    state_next = last ? ST_MERGE : ST_RD_LIVE;
      ST_MERGE:   state_next = ST_RD_LAST;
      ST_RD_LAST: state_next = ST_MOVE;
      ST_MOVE:    state_next = (m == SB'(NUM_SYMBOLS - 2)) ? ST_WROOT : ST_RD_LIVE;
      ST_WROOT:   state_next = ST_WRD;
      ST_WRD:     state_next = ST_WL;
      ST_WL:      state_next = ST_WR;
      ST_WR:      state_next = (m == '0) ? ST_RESP : ST_WRD;
      ST_LOOKUP:  state_next = ST_RESP;
      ST_DECODE:  state_next = ST_RESP;
      ST_RESP:    if (ctl.take) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    counts_we = 1'b0; counts_re = 1'b0;
    counts_waddr = req.symbol[SB-1:0];
    counts_raddr = live_q[SB-1:0];
    node_we = 1'b0; node_re = 1'b0;
    node_raddr = live_off[SB-1:0];
    lr_we = 1'b0; lr_re = 1'b0;
    lr_raddr = pos_off[SB-1:0];
    live_we = 1'b0; live_re = 1'b0;
    live_waddr = i; live_raddr = i;
    live_wdata = NB'(i);
    walk_we = 1'b0; walk_re = 1'b0;
    walk_waddr = child;
    walk_raddr = NB'(req.symbol[SB-1:0]);
    walk_wdata = {ncode, nlen};
    unique case (state)
      ST_IDLE: begin
        counts_we = ctl.start && (req.req_type == REQ_LOAD) && sym_ok;
        walk_re   = ctl.start && (req.req_type == REQ_LOOKUP);
        lr_re     = ctl.start && (req.req_type == REQ_DECODE);
      end
      ST_INIT:    live_we = 1'b1;
      ST_RD_LIVE: live_re = 1'b1;
      ST_RD_NODE: begin
        counts_re = 1'b1;
        node_re   = (live_q >= NB'(NUM_SYMBOLS));
      end
      ST_MERGE: begin
        node_we    = 1'b1;
        lr_we      = 1'b1;
        live_we    = 1'b1;
        live_waddr = first_idx;
        live_wdata = parent;
      end
      ST_RD_LAST: begin
        live_re    = 1'b1;
        live_raddr = SB'(cnt - (SB+1)'(1));
      end
      ST_MOVE: begin
        live_we    = 1'b1;
        live_waddr = second_idx;
        live_wdata = live_q;
      end
      ST_WROOT: begin
        walk_we    = 1'b1;
        walk_waddr = NB'(ROOT);
        walk_wdata = '0;
      end
      ST_WRD: begin
        lr_re      = 1'b1;
        lr_raddr   = m;
        walk_re    = 1'b1;
        walk_raddr = parent;
      end
      ST_WL, ST_WR: walk_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (counts_we) counts_mem[counts_waddr] <= COUNT_BITS'(req.frequency);
    if (counts_re) counts_q <= counts_vld[counts_raddr] ? counts_mem[counts_raddr] : '0;
    if (node_we) node_mem[m] <= {sum, low_min};
    if (node_re) node_q <= node_mem[node_raddr];
    if (lr_we) lr_mem[m] <= {first_node, second_node};
    if (lr_re) lr_q <= lr_mem[lr_raddr];
    if (live_we) live_mem[live_waddr] <= live_wdata;
    if (live_re) live_q <= live_mem[live_raddr];
    if (walk_we) walk_mem[walk_waddr] <= walk_wdata;
    if (walk_re) walk_q <= walk_mem[walk_raddr];
  end

  // counts read as zero until loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_vld <= '0;
    end else if (counts_we) begin
      counts_vld[counts_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_ready  <= 1'b0;
      pos         <= NB'(ROOT);
      have_first  <= 1'b0;
      have_second <= 1'b0;
      too_long    <= 1'b0;
      i           <= '0;
      cnt         <= '0;
      m           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            req_q                 <= req;
            i                     <= '0;
            too_long              <= 1'b0;
            result.status         <= not_built ? STS_NOT_BUILT : STS_OK;
            result.symbol_valid   <= 1'b0;
            result.decoded_symbol <= '0;
            result.code_value     <= '0;
            result.code_length    <= '0;
          end
        end
        ST_INIT: begin
          if (i == SB'(NUM_SYMBOLS - 1)) begin
            i           <= '0;
            cnt         <= (SB+1)'(NUM_SYMBOLS);
            m           <= '0;
            have_first  <= 1'b0;
            have_second <= 1'b0;
          end else begin
            i <= i + SB'(1);
          end
        end
        ST_RD_NODE: begin
          cur_node <= live_q;
          cur_leaf <= (live_q < NB'(NUM_SYMBOLS));
        end
        ST_CMP: begin
          if (!have_first || less) begin
            second_key  <= first_key;
            second_node <= first_node;
            second_idx  <= first_idx;
            have_second <= have_first;
            first_key   <= cur_key;
            first_node  <= cur_node;
            first_idx   <= i;
            have_first  <= 1'b1;
            i           <= i + SB'(1);
          end
        end
        ST_CMP2: begin
          if (!have_second || less) begin
            second_key  <= cur_key;
            second_node <= cur_node;
            second_idx  <= i;
            have_second <= 1'b1;
          end
          i <= i + SB'(1);
        end
        ST_MOVE: begin
          cnt         <= cnt - (SB+1)'(1);
          i           <= '0;
          have_first  <= 1'b0;
          have_second <= 1'b0;
          if (m != SB'(NUM_SYMBOLS - 2)) m <= m + SB'(1);
        end
        ST_WL: begin
          if (child_long) too_long <= 1'b1;
        end
        ST_WR: begin
          if (child_long) too_long <= 1'b1;
          if (m == '0) begin
            tree_ready    <= 1'b1;
            pos           <= NB'(ROOT);
            result.status <= (too_long || child_long) ? STS_TOO_LONG : STS_OK;
          end else begin
            m <= m - SB'(1);
          end
        end
        ST_LOOKUP: begin
          if (plen > LB'(MAX_CODE_BITS)) begin
            result.status <= STS_TOO_LONG;
          end else begin
            result.code_value  <= 64'(pcode);
            result.code_length <= 7'(plen);
          end
        end
        ST_DECODE: begin
          if (dec_next < NB'(NUM_SYMBOLS)) begin
            result.symbol_valid   <= 1'b1;
            result.decoded_symbol <= 8'(dec_next);
            pos                   <= NB'(ROOT);
          end else begin
            pos <= dec_next;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.idle = (state == ST_IDLE);
  assign sts.done = (state == ST_RESP);

  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> have_first && have_second && first_node != second_node)
    else $error("merge of a node with itself");

  a_pos_internal: assert property (@(posedge clk) disable iff (rst)
    pos >= NB'(NUM_SYMBOLS))
    else $error("decode position left the internal nodes");

  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    tree_ready |=> tree_ready)
    else $error("tree ready dropped");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESP && !ctl.take |=> state == ST_RESP && $stable(result))
    else $error("pending result changed");

endmodule

@@ sv/huffman_code_builder_decoder.sv @@
// Huffman code builder and decoder over a table of NUM_SYMBOLS symbol counts.
// One item is in work at a time. A build first writes the live list, then
// runs NUM_SYMBOLS-1 merges; each merge scans the live list through a single
// key comparator and then retires the merge, and a code walk over the
// internal nodes follows. A finished result sits in an output register so
// the next request may be transferred while it waits.
module huffman_code_builder_decoder #(
  parameter int NUM_SYMBOLS   = hcb_pkg::NUM_SYMBOLS_DEF,
  parameter int COUNT_BITS    = hcb_pkg::COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = hcb_pkg::MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  hcb_pkg::hcb_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output hcb_pkg::hcb_rsp_t rsp
);
  import hcb_pkg::*;

  eng_ctl_t ctl;
  eng_sts_t sts;
  hcb_rsp_t result;

  assign req_stall = !sts.idle;
  assign ctl.start = req_valid && sts.idle;
  assign ctl.take  = sts.done && (!rsp_valid || !rsp_stall);

  hcb_engine #(
    .NUM_SYMBOLS   (NUM_SYMBOLS),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req),
    .sts    (sts),
    .result (result)
  );

  // output register, refilled as the previous result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) rsp <= result;
  end

endmodule

@@ test/huffman_code_builder_decoder_tb.sv @@
module huffman_code_builder_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hcb_pkg::*;

  localparam int NSYM = 256;
  localparam int ROOT = 2 * NSYM - 2;
  localparam int MAXB = 64;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  hcb_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  hcb_rsp_t rsp;

  huffman_code_builder_decoder u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's tables
  logic [31:0]     counts[NSYM];
  logic [8:0]      left_of[NSYM-1];
  logic [8:0]      right_of[NSYM-1];
  longint unsigned weight_of[2*NSYM-1];
  logic [7:0]      low_of[2*NSYM-1];
  int              live[NSYM];
  logic [63:0]     code_of[NSYM];
  int              len_of[NSYM];
  logic [63:0]     walk_code[2*NSYM-1];
  int              walk_len[2*NSYM-1];
  int              dec_pos;
  bit              codes_built;

  hcb_req_t pending_reqs[$];
  bit       drain_first[$];
  hcb_rsp_t expected_rsps[$];
  int       mismatches = 0;
  int       req_gap = 0;
  int       rsp_gap = 0;
  bit       quiet;

  assign quiet = pending_reqs.size() < 60;

  function automatic bit node_less(int a, int b);
    if (weight_of[a] != weight_of[b]) return weight_of[a] < weight_of[b];
    return low_of[a] < low_of[b];
  endfunction

  function automatic void give_child(int child, int parent, logic bitv);
    int l;
    l = walk_len[parent];
    if (l <= MAXB) l = l + 1;
    walk_len[child] = l;
    walk_code[child] = {walk_code[parent][62:0], bitv};
  endfunction

  function automatic bit build_codes();
    int n, first, second, p, a, b;
    bit too_long;
    n = NSYM;
    too_long = 0;
    for (int i = 0; i < NSYM; i++) begin
      weight_of[i] = counts[i];
      low_of[i] = i[7:0];
      live[i] = i;
    end
    for (int m = 0; m < NSYM - 1; m++) begin
      first = 0;
      second = 1;
      p = NSYM + m;
      if (node_less(live[1], live[0])) begin
        first = 1;
        second = 0;
      end
      for (int i = 2; i < n; i++) begin
        if (node_less(live[i], live[first])) begin
          second = first;
          first = i;
        end else if (node_less(live[i], live[second])) begin
          second = i;
        end
      end
      a = live[first];
      b = live[second];
      left_of[m] = a[8:0];
      right_of[m] = b[8:0];
      weight_of[p] = weight_of[a] + weight_of[b];
      low_of[p] = (low_of[a] < low_of[b]) ? low_of[a] : low_of[b];
      live[first] = p;
      live[second] = live[n-1];
      n--;
    end
    walk_code[ROOT] = '0;
    walk_len[ROOT] = 0;
    for (int m = NSYM - 1; m > 0; m--) begin
      give_child(left_of[m-1], NSYM + m - 1, 1'b0);
      give_child(right_of[m-1], NSYM + m - 1, 1'b1);
    end
    for (int i = 0; i < NSYM; i++) begin
      code_of[i] = walk_code[i];
      len_of[i] = walk_len[i];
      if (walk_len[i] > MAXB) too_long = 1;
    end
    dec_pos = ROOT;
    codes_built = 1;
    return too_long;
  endfunction

  function automatic hcb_rsp_t predict_rsp(hcb_req_t r);
    hcb_rsp_t o;
    int pos;
    o = '0;
    o.status = STS_OK;
    if (r.req_type == REQ_LOAD) begin
      counts[r.symbol] = r.frequency;
    end else if (r.req_type == REQ_BUILD) begin
      if (build_codes()) o.status = STS_TOO_LONG;
    end else if (!codes_built) begin
      o.status = STS_NOT_BUILT;
    end else if (r.req_type == REQ_LOOKUP) begin
      if (len_of[r.symbol] > MAXB) begin
        o.status = STS_TOO_LONG;
      end else begin
        o.code_value = code_of[r.symbol];
        o.code_length = len_of[r.symbol][6:0];
      end
    end else begin
      pos = dec_pos;
      if (pos < NSYM || pos > ROOT) pos = ROOT;
      pos = r.code_bit ? right_of[pos-NSYM] : left_of[pos-NSYM];
      if (pos < NSYM) begin
        o.symbol_valid = 1'b1;
        o.decoded_symbol = pos[7:0];
        pos = ROOT;
      end
      dec_pos = pos;
    end
    return o;
  endfunction

  function automatic void add_req(req_type_t t, int sym, logic [31:0] freq, logic b,
                                  bit drain = 0);
    hcb_req_t r;
    r.req_type = t;
    r.symbol = sym[7:0];
    r.frequency = freq;
    r.code_bit = b;
    pending_reqs.push_back(r);
    drain_first.push_back(drain);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) expected_rsps.push_back(predict_rsp(req));
      if (req_valid && req_stall) begin
        // hold the stalled transfer
      end else if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (drain_first[0] && expected_rsps.size() != 0)) begin
        req_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        req_gap <= $urandom_range(0, 6);
        req_valid <= 1'b0;
      end else begin
        req <= pending_reqs.pop_front();
        void'(drain_first.pop_front());
        req_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hcb_rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", rsp);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status || rsp.symbol_valid !== e.symbol_valid ||
              rsp.decoded_symbol !== e.decoded_symbol ||
              rsp.code_value !== e.code_value || rsp.code_length !== e.code_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st=%0d sv=%0d sym=%0d code=%h len=%0d,",
                        " got st=%0d sv=%0d sym=%0d code=%h len=%0d"},
                       e.status, e.symbol_valid, e.decoded_symbol, e.code_value,
                       e.code_length, rsp.status, rsp.symbol_valid, rsp.decoded_symbol,
                       rsp.code_value, rsp.code_length);
          end
        end
      end
      if (quiet) begin
        rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        rsp_gap <= $urandom_range(0, 6);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    longint unsigned fa, fb, fc;
    int style;
    for (int i = 0; i < NSYM; i++) counts[i] = '0;
    dec_pos = ROOT;
    codes_built = 0;

    // before any build
    add_req(REQ_LOOKUP, 0, '0, 1'b0);
    add_req(REQ_DECODE, 0, '1, 1'b1);
    add_req(REQ_LOAD, 0, 32'hffff_ffff, 1'b1);
    add_req(REQ_LOAD, 255, 32'h0, 1'b0);
    add_req(REQ_LOAD, 7, 32'd5, 1'b0);
    add_req(REQ_LOAD, 8, 32'd5, 1'b1);
    // mostly equal zero weights, ties go to the lower symbol
    add_req(REQ_BUILD, 0, '0, 1'b0, 1);
    add_req(REQ_LOOKUP, 0, '0, 1'b0);
    add_req(REQ_LOOKUP, 255, '1, 1'b1);
    add_req(REQ_LOOKUP, 7, '0, 1'b0);
    add_req(REQ_LOOKUP, 8, '0, 1'b0);
    add_req(REQ_DECODE, 0, '0, 1'b1);
    for (int i = 0; i < 9; i++) add_req(REQ_DECODE, 0, '0, 1'b0);
    // loads after a build leave codes alone
    add_req(REQ_LOAD, 3, 32'd9, 1'b0);
    add_req(REQ_LOOKUP, 3, '0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        // fibonacci weights give a deep skewed tree
        fa = 1;
        fb = 1;
        for (int s = 0; s < NSYM; s++) begin
          if (fa <= 64'hffff_ffff) add_req(REQ_LOAD, s, fa[31:0], s[0]);
          else add_req(REQ_LOAD, s, 32'h0, s[0]);
          fc = fa + fb;
          fa = fb;
          fb = fc;
          if (s > 50) s = NSYM;
        end
      end
      style = ph;
      for (int i = 0; i < 110; i++)
        add_req(REQ_LOAD, $urandom_range(0, 255),
                (style == 1) ? 32'($urandom_range(0, 15)) : $urandom, $urandom_range(0, 1));
      add_req(REQ_BUILD, $urandom_range(0, 255), $urandom, $urandom_range(0, 1), 1);
      for (int i = 0; i < 70; i++) begin
        case ($urandom_range(0, 5))
          0: add_req(REQ_LOAD, $urandom_range(0, 255), $urandom, $urandom_range(0, 1));
          1, 2: add_req(REQ_LOOKUP, $urandom_range(0, 255), $urandom, $urandom_range(0, 1));
          default: add_req(REQ_DECODE, $urandom_range(0, 255), $urandom,
                           $urandom_range(0, 1));
        endcase
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[huffman_code_builder_decoder] OK");
    end else begin
      $display("[huffman_code_builder_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[huffman_code_builder_decoder] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
sv/hcb_pkg.sv
sv/hcb_cmp.sv
sv/hcb_engine.sv
sv/huffman_code_builder_decoder.sv
test/huffman_code_builder_decoder_tb.sv
